>>> sv/gaussian_disc_point_sampler_assert.svh
// ----------------------------------------------------------------------------
// Gaussian disc point sampler assertion macros
// Concurrent assertion shorthands clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_DISC_POINT_SAMPLER_ASSERT_SVH
`define GAUSSIAN_DISC_POINT_SAMPLER_ASSERT_SVH

// property checked outside reset
`define GDPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked during reset too
`define GDPS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> sv/gdps_pkg.sv
// ----------------------------------------------------------------------------
// Gaussian disc point sampler package
// Shared constants, register codes, cell state types and the CORDIC table.
// ----------------------------------------------------------------------------
`default_nettype none

package gdps_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic [31:0]        LN2_Q32      = 32'd2977044472;
    localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;

    // configuration register codes
    typedef enum logic [2:0] {
        REG_RADIAL_SCALE = 3'd0,
        REG_CENTRE_X     = 3'd1,
        REG_CENTRE_Y     = 3'd2,
        REG_CENTRE_Z     = 3'd3,
        REG_ROT_COL1     = 3'd4,
        REG_ROT_COL2     = 3'd5
    } cfg_reg_t;

    // state handed between cordic cells
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic [1:0]         quad;
    } cordic_t;

    // state handed between square root cells
    typedef struct packed {
        logic [63:0] v;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_t;

    // arctangent of 2^-idx in 2^-32 turn units
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] a;
        case (idx)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2F9;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            24: a = 32'h00000029;
            25: a = 32'h00000014;
            26: a = 32'h0000000A;
            27: a = 32'h00000005;
            28: a = 32'h00000003;
            29: a = 32'h00000001;
            30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

>>> sv/gdps_log_cell.sv
// ----------------------------------------------------------------------------
// Logarithm cell
// One shift-and-square step of the base-2 logarithm, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gdps_log_cell
    import gdps_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic [31:0]          in_x,
    input  wire logic [FRAC_BITS-1:0] in_l,
    input  wire logic [5:0]           in_p,
    output logic      [31:0]          out_x_reg,
    output logic      [FRAC_BITS-1:0] out_l_reg,
    output logic      [5:0]           out_p_reg
);

    logic [63:0] sq;
    logic [32:0] sq_hi;
    logic [31:0] x_next;
    logic [FRAC_BITS-1:0] l_next;

    // square the mantissa, renormalise and take one result bit
    always_comb begin
        sq     = 64'(in_x) * 64'(in_x);
        sq_hi  = sq[63:31];
        if (sq_hi[32]) begin
            x_next = sq_hi[32:1];
        end else begin
            x_next = sq_hi[31:0];
        end
        l_next = {in_l[FRAC_BITS-2:0], sq_hi[32]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_x_reg <= x_next;
            out_l_reg <= l_next;
            out_p_reg <= in_p;
        end
    end

endmodule

`default_nettype wire

>>> sv/gdps_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One restoring digit of the integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gdps_sqrt_cell
    import gdps_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire sqrt_t in_st,
    output sqrt_t      out_st_reg
);

    logic [35:0] rem2;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;
    sqrt_t       st_next;

    // bring down two radicand bits and try the next root bit
    always_comb begin
        rem2          = {in_st.rem, in_st.v[63:62]};
        trial         = {2'b00, in_st.root, 2'b01};
        diff          = rem2 - trial;
        ge            = (rem2 >= trial);
        st_next.v     = {in_st.v[61:0], 2'b00};
        st_next.rem   = ge ? diff[33:0] : rem2[33:0];
        st_next.root  = {in_st.root[30:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/gdps_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode CORDIC micro-rotation with a fixed shift, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gdps_cordic_cell
    import gdps_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic    aclk,
    input  wire logic    en,
    input  wire cordic_t in_st,
    output cordic_t      out_st_reg
);

    localparam logic signed [32:0] ATAN = $signed({1'b0, atan_turn(IDX)});

    logic signed [33:0] dx;
    logic signed [33:0] dy;
    cordic_t            st_next;

    // rotate towards zero residual angle
    always_comb begin
        dx = in_st.x >>> IDX;
        dy = in_st.y >>> IDX;
        st_next.quad = in_st.quad;
        if (!in_st.z[32]) begin
            st_next.x = in_st.x - dy;
            st_next.y = in_st.y + dx;
            st_next.z = in_st.z - ATAN;
        end else begin
            st_next.x = in_st.x + dy;
            st_next.y = in_st.y - dx;
            st_next.z = in_st.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/gaussian_disc_point_sampler.sv
// Throughput: one transaction per cycle; the whole cell chain advances together
// and stalls only while the output register holds a result not yet taken.
// The pipeline is the chain of log, square root and CORDIC cells, one step per cell.
// Reset (aresetn low, synchronous) empties the pipeline and restores registers.
// ----------------------------------------------------------------------------
// Gaussian disc point sampler
// Radius from -ln(1-u1) and a square root, angle by CORDIC, then rotation
// into the disc plane, centre offset and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_disc_point_sampler
    import gdps_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [53:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [31:0]        s_uniform_radius,
    input  wire logic [31:0]        s_uniform_angle,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_point_x,
    output logic signed [31:0]      m_point_y,
    output logic signed [31:0]      m_point_z
);

    localparam int TW   = FRAC_BITS + 6;
    localparam int NVLD = FRAC_BITS + 37;
    localparam int DLY  = FRAC_BITS + 35 - CORDIC_STEPS;
    localparam int SHL  = (FRAC_BITS <= 16) ? (16 - FRAC_BITS) : 0;
    localparam int SHR  = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;

    // configuration registers
    logic [31:0]        scale_reg;
    logic signed [31:0] centre_x_reg, centre_y_reg, centre_z_reg;
    logic [53:0]        col1_reg, col2_reg;

    logic en;
    logic [NVLD-1:0] vld_reg;
    logic            m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg    <= '0;
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            centre_z_reg <= '0;
            col1_reg     <= 54'd65536;
            col2_reg     <= 54'd17179869184;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_RADIAL_SCALE: scale_reg    <= cfg_wr_data[31:0];
                REG_CENTRE_X:     centre_x_reg <= $signed(cfg_wr_data[31:0]);
                REG_CENTRE_Y:     centre_y_reg <= $signed(cfg_wr_data[31:0]);
                REG_CENTRE_Z:     centre_z_reg <= $signed(cfg_wr_data[31:0]);
                REG_ROT_COL1:     col1_reg     <= cfg_wr_data;
                REG_ROT_COL2:     col2_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // chain advance whenever the output register can take a result
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[NVLD-2:0], s_valid};
            m_valid_reg <= vld_reg[NVLD-1];
        end
    end

    // normalise 2^32 - u1 to a mantissa in [1,2)
    logic [32:0] w;
    logic [5:0]  p;
    logic [63:0] xs;
    logic [31:0] x0;

    always_comb begin
        w = 33'h1_0000_0000 - {1'b0, s_uniform_radius};
        p = '0;
        for (int i = 0; i < 33; i++) begin
            if (w[i]) begin
                p = 6'(i);
            end
        end
        xs = 64'(w) << (6'd31 - p);
        if (p == 6'd32) begin
            x0 = 32'h8000_0000;
        end else begin
            x0 = xs[31:0];
        end
    end

    logic [31:0]          lx_x_reg [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] lx_l_reg [0:FRAC_BITS];
    logic [5:0]           lx_p_reg [0:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            lx_x_reg[0] <= x0;
            lx_l_reg[0] <= '0;
            lx_p_reg[0] <= p;
        end
    end

    // logarithm cells
    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_log
        gdps_log_cell #(.FRAC_BITS(FRAC_BITS)) u_log (
            .aclk      (aclk),
            .en        (en),
            .in_x      (lx_x_reg[k]),
            .in_l      (lx_l_reg[k]),
            .in_p      (lx_p_reg[k]),
            .out_x_reg (lx_x_reg[k+1]),
            .out_l_reg (lx_l_reg[k+1]),
            .out_p_reg (lx_p_reg[k+1])
        );
    end

    // natural log and radius squared
    logic [TW-1:0]    t;
    logic [TW+31:0]   tprod;
    logic [TW-1:0]    n_next, n_reg;
    logic [63:0]      r2f;
    logic [63:0]      r2_next;
    sqrt_t            sq_st [0:32];

    always_comb begin
        t      = (TW'(6'd32 - lx_p_reg[FRAC_BITS]) << FRAC_BITS)
                 - TW'(lx_l_reg[FRAC_BITS]);
        tprod  = (TW+32)'(t) * (TW+32)'(LN2_Q32);
        n_next = tprod[TW+31:32];
        r2f    = 64'(scale_reg) * 64'(n_reg);
        r2_next = (r2f << SHL) >> SHR;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg         <= n_next;
            sq_st[0].v    <= r2_next;
            sq_st[0].rem  <= '0;
            sq_st[0].root <= '0;
        end
    end

    // square root cells
    for (genvar j = 0; j < 32; j++) begin : g_sqrt
        gdps_sqrt_cell u_sqrt (
            .aclk       (aclk),
            .en         (en),
            .in_st      (sq_st[j]),
            .out_st_reg (sq_st[j+1])
        );
    end

    // cordic cells, fed straight from the input transaction
    cordic_t cst [0:CORDIC_STEPS];

    always_comb begin
        cst[0].x    = CORDIC_K_Q30;
        cst[0].y    = '0;
        cst[0].z    = $signed({3'b000, s_uniform_angle[29:0]});
        cst[0].quad = s_uniform_angle[31:30];
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        gdps_cordic_cell #(.IDX(i)) u_cordic (
            .aclk       (aclk),
            .en         (en),
            .in_st      (cst[i]),
            .out_st_reg (cst[i+1])
        );
    end

    // quadrant fold and alignment with the radius
    logic signed [33:0] cos_q, sin_q;
    logic signed [33:0] dly_c_reg [0:DLY-1];
    logic signed [33:0] dly_s_reg [0:DLY-1];

    always_comb begin
        case (cst[CORDIC_STEPS].quad)
            2'd0: begin
                cos_q = cst[CORDIC_STEPS].x;
                sin_q = cst[CORDIC_STEPS].y;
            end
            2'd1: begin
                cos_q = -cst[CORDIC_STEPS].y;
                sin_q = cst[CORDIC_STEPS].x;
            end
            2'd2: begin
                cos_q = -cst[CORDIC_STEPS].x;
                sin_q = -cst[CORDIC_STEPS].y;
            end
            default: begin
                cos_q = cst[CORDIC_STEPS].y;
                sin_q = -cst[CORDIC_STEPS].x;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dly_c_reg[0] <= cos_q;
            dly_s_reg[0] <= sin_q;
            for (int d = 1; d < DLY; d++) begin
                dly_c_reg[d] <= dly_c_reg[d-1];
                dly_s_reg[d] <= dly_s_reg[d-1];
            end
        end
    end

    // local point in the disc plane
    logic signed [27:0] r_s;
    logic signed [61:0] pcx, pcy;
    logic signed [31:0] lx_reg, ly_reg;

    always_comb begin
        r_s = $signed({1'b0, sq_st[32].root[26:0]});
        pcx = 62'(r_s) * 62'(dly_c_reg[DLY-1]);
        pcy = 62'(r_s) * 62'(dly_s_reg[DLY-1]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lx_reg <= pcx[61:30];
            ly_reg <= pcy[61:30];
        end
    end

    // rotation products
    logic signed [17:0] e1 [0:2];
    logic signed [17:0] e2 [0:2];
    logic signed [49:0] pa_reg [0:2];
    logic signed [49:0] pb_reg [0:2];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            e1[c] = $signed(col1_reg[18*c +: 18]);
            e2[c] = $signed(col2_reg[18*c +: 18]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                pa_reg[c] <= 50'(e1[c]) * 50'(lx_reg);
                pb_reg[c] <= 50'(e2[c]) * 50'(ly_reg);
            end
        end
    end

    // centre offset, rescale and saturate
    logic signed [31:0] centre [0:2];
    logic signed [51:0] acc    [0:2];
    logic signed [35:0] val    [0:2];
    logic signed [31:0] sat    [0:2];

    always_comb begin
        centre[0] = centre_x_reg;
        centre[1] = centre_y_reg;
        centre[2] = centre_z_reg;
        for (int c = 0; c < 3; c++) begin
            acc[c] = 52'(pa_reg[c]) + 52'(pb_reg[c]) + (52'(centre[c]) <<< 16);
            val[c] = acc[c][51:16];
            if (val[c] > 36'sd2147483647) begin
                sat[c] = 32'sh7FFF_FFFF;
            end else if (val[c] < -36'sd2147483648) begin
                sat[c] = 32'sh8000_0000;
            end else begin
                sat[c] = val[c][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_point_x <= sat[0];
            m_point_y <= sat[1];
            m_point_z <= sat[2];
        end
    end

endmodule

`default_nettype wire

>>> sv/gdps_checker.sv
// ----------------------------------------------------------------------------
// Gaussian disc point sampler checker
// Port-level checks of the result channel and the stall path.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gaussian_disc_point_sampler_assert.svh"

module gdps_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_point_x,
    input wire logic [31:0] m_point_y,
    input wire logic [31:0] m_point_z
);

    // an empty output register never blocks the input
    `GDPS_ASSERT(a_idle_ready, !m_valid |-> s_ready, "input stalled with empty output")

    // a result that is taken frees the input in the same cycle
    `GDPS_ASSERT(a_take_ready, m_valid && m_ready |-> s_ready, "input stalled while result taken")

    // a waiting result holds until its transaction
    `GDPS_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_point_x) && $stable(m_point_y) && $stable(m_point_z), "result changed while stalled")

    // reset empties the output
    `GDPS_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind gaussian_disc_point_sampler gdps_checker u_gdps_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_point_x (m_point_x),
    .m_point_y (m_point_y),
    .m_point_z (m_point_z)
);

`default_nettype wire
